// ----- sv/sha1_hash_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_TOP_MACROS_SVH
`define SHA1_HASH_ENGINE_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define SHA1_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types, state encodings, constants and round functions.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned ROUND_W     = 7;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned NB_W        = 3;
  localparam int unsigned LEN_W       = 64;

  typedef logic [WORD_W-1:0]                     word_t;
  typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0]    chain_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]    block_t;

  localparam chain_t IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                           32'hefcdab89, 32'h67452301};

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam word_t PAD_WORD = 32'h80000000;

  localparam logic [POS_W-1:0] LEN_HI_POS = 4'd14;
  localparam logic [POS_W-1:0] LAST_POS   = 4'd15;
  localparam logic [IDX_W-1:0] LAST_IDX   = 3'd4;
  localparam logic [NB_W-1:0]  FULL_BYTES = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_WAIT,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_e;

  typedef struct packed {
    logic push;
    logic block_end;
    logic init;
  } core_ctl_t;

  function automatic word_t sha1_k(input logic [ROUND_W-1:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic word_t sha1_f(input logic [ROUND_W-1:0] rnd,
                                   input word_t b, input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Keep the leading valid bytes and place the pad byte right after them.
  function automatic word_t sha1_tail(input word_t w, input logic [NB_W-1:0] nb);
    word_t t;
    case (nb)
      3'd1:    t = (w & 32'hff000000) | 32'h00800000;
      3'd2:    t = (w & 32'hffff0000) | 32'h00008000;
      3'd3:    t = (w & 32'hffffff00) | 32'h00000080;
      default: t = PAD_WORD;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/sha1_core.sv -----
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Block shift line, one round unit reused for 80 rounds, chaining words.
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_top_macros.svh"

module sha1_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha1_pkg::core_ctl_t  ctl_i,
  input  sha1_pkg::word_t      word_i,
  output logic                 busy_o,
  output sha1_pkg::chain_t     chain_o
);

  localparam logic [sha1_pkg::ROUND_W-1:0] LAST_ROUND =
    sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1);

  sha1_pkg::core_state_e            state_q, state_d;
  logic [sha1_pkg::ROUND_W-1:0]     round_q, round_d;
  sha1_pkg::chain_t                 h_q, h_d;
  sha1_pkg::chain_t                 work_q, work_d;
  sha1_pkg::block_t                 w_q, w_d;
  sha1_pkg::word_t                  sched;
  sha1_pkg::word_t                  mix;
  sha1_pkg::word_t                  tmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::CORE_IDLE;
      round_q <= '0;
      h_q     <= sha1_pkg::IV;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    work_q <= work_d;
  end

  // Message schedule: w_q[0] is the current round's word.
  assign mix   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign sched = {mix[30:0], mix[31]};

  assign tmp = {work_q[0][26:0], work_q[0][31:27]}
             + sha1_pkg::sha1_f(round_q, work_q[1], work_q[2], work_q[3])
             + work_q[4] + sha1_pkg::sha1_k(round_q) + w_q[0];

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    h_d     = h_q;
    work_d  = work_q;
    w_d     = w_q;
    unique case (state_q)
      sha1_pkg::CORE_IDLE: begin
        if (ctl_i.push) begin
          w_d = {word_i, w_q[15:1]};
          if (ctl_i.block_end) begin
            work_d  = h_q;
            round_d = '0;
            state_d = sha1_pkg::CORE_ROUND;
          end
        end
        if (ctl_i.init) begin
          h_d = sha1_pkg::IV;
        end
      end
      sha1_pkg::CORE_ROUND: begin
        w_d       = {sched, w_q[15:1]};
        work_d[0] = tmp;
        work_d[1] = work_q[0];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[3] = work_q[2];
        work_d[4] = work_q[3];
        round_d   = round_q + 1'b1;
        if (round_q == LAST_ROUND) begin
          state_d = sha1_pkg::CORE_ADD;
        end
      end
      sha1_pkg::CORE_ADD: begin
        for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
          h_d[i] = h_q[i] + work_q[i];
        end
        state_d = sha1_pkg::CORE_IDLE;
      end
      default: begin
        state_d = sha1_pkg::CORE_IDLE;
      end
    endcase
  end

  assign busy_o  = (state_q != sha1_pkg::CORE_IDLE);
  assign chain_o = h_q;

  `SHA1_ASSERT_NOW(a_push_when_idle, ctl_i.push, state_q == sha1_pkg::CORE_IDLE, "push during compression")
  `SHA1_ASSERT_NOW(a_round_bound, state_q == sha1_pkg::CORE_ROUND, round_q <= LAST_ROUND, "round count overrun")
  `SHA1_ASSERT_NEXT(a_add_after_last, state_q == sha1_pkg::CORE_ROUND && round_q == LAST_ROUND, state_q == sha1_pkg::CORE_ADD, "feed-forward missed")

endmodule

// ----- sv/sha1_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams big-endian message words, pads at end of message and returns the
// 160-bit digest as five words.
// ----------------------------------------------------------------------------
// A message arrives as 32-bit words, first byte in bits 31..24, one word per
// input transfer. Words without the end mark always count as four bytes; the
// end-marked word carries 0 to 4 valid bytes (higher counts are saturated to
// 4, unused bytes are zeroed). Each word enters the block shift line; the
// sixteenth word of a block starts the compression, which runs one round per
// cycle through a single round unit for 80 rounds followed by a feed-forward
// addition step, and input is stalled during compression. At end of message
// the engine appends the 0x80 byte, zero words and the 64-bit bit length one
// word per cycle while the core is not compressing, needing one or two further
// compressions, and then offers the five digest words on the
// output, index 0 first, with digest_last on index 4. After the last digest
// transfer the chaining words return to the initial vector and the length and
// word count clear, ready for the next message. There is no clearing pass
// after reset; the engine takes input as soon as reset is released.
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_top_macros.svh"

module sha1_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        end_of_message_i,
  // digest output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  sha1_pkg::top_state_e              state_q, state_d;
  logic [sha1_pkg::POS_W-1:0]        pos_q, pos_d;
  logic [sha1_pkg::LEN_W-1:0]        bitlen_q, bitlen_d;
  logic [sha1_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic                              extra_q, extra_d;   // full last word: pad word pending
  logic                              lenhi_q, lenhi_d;   // upper length word already pushed

  sha1_pkg::core_ctl_t               ctl;
  sha1_pkg::word_t                   push_word;
  sha1_pkg::chain_t                  chain;
  logic                              core_busy;
  logic                              in_xfer;
  logic                              out_xfer;
  logic [sha1_pkg::NB_W-1:0]         nb_sat;

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .word_i  (push_word),
    .busy_o  (core_busy),
    .chain_o (chain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha1_pkg::ST_IDLE;
      pos_q    <= '0;
      bitlen_q <= '0;
      idx_q    <= '0;
      extra_q  <= 1'b0;
      lenhi_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      bitlen_q <= bitlen_d;
      idx_q    <= idx_d;
      extra_q  <= extra_d;
      lenhi_q  <= lenhi_d;
    end
  end

  // Take words only while idle and the core is not compressing.
  assign in_stall_o = !(state_q == sha1_pkg::ST_IDLE && !core_busy);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign out_valid_o = (state_q == sha1_pkg::ST_OUT);
  assign out_xfer    = out_valid_o && !out_stall_i;

  // Saturate the final word's byte count to four.
  assign nb_sat = (valid_bytes_i > sha1_pkg::FULL_BYTES) ? sha1_pkg::FULL_BYTES
                                                         : valid_bytes_i;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    bitlen_d      = bitlen_q;
    idx_d         = idx_q;
    extra_d       = extra_q;
    lenhi_d       = lenhi_q;
    ctl.push      = 1'b0;
    ctl.block_end = 1'b0;
    ctl.init      = 1'b0;
    push_word     = '0;

    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ctl.push = 1'b1;
          if (!end_of_message_i) begin
            push_word = message_word_i;
            bitlen_d  = bitlen_q + 64'd32;
          end else begin
            push_word = (nb_sat == sha1_pkg::FULL_BYTES) ? message_word_i
                      : sha1_pkg::sha1_tail(message_word_i, nb_sat);
            bitlen_d  = bitlen_q + {58'd0, nb_sat, 3'b000};
            extra_d   = (nb_sat == sha1_pkg::FULL_BYTES);
            lenhi_d   = 1'b0;
            state_d   = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        // Push one padding word per cycle whenever the core is free.
        if (!core_busy) begin
          ctl.push = 1'b1;
          if (extra_q) begin
            push_word = sha1_pkg::PAD_WORD;
            extra_d   = 1'b0;
          end else if (lenhi_q) begin
            push_word = bitlen_q[31:0];
            state_d   = sha1_pkg::ST_WAIT;
          end else if (pos_q == sha1_pkg::LEN_HI_POS) begin
            push_word = bitlen_q[63:32];
            lenhi_d   = 1'b1;
          end else begin
            push_word = '0;
          end
        end
      end
      sha1_pkg::ST_WAIT: begin
        if (!core_busy) begin
          idx_d   = '0;
          state_d = sha1_pkg::ST_OUT;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (idx_q == sha1_pkg::LAST_IDX) begin
            ctl.init = 1'b1;
            pos_d    = '0;
            bitlen_d = '0;
            state_d  = sha1_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase

    // Advance the word position; the sixteenth word starts a compression.
    if (ctl.push) begin
      ctl.block_end = (pos_q == sha1_pkg::LAST_POS);
      pos_d         = pos_q + 1'b1;
    end
  end

  always_comb begin
    case (idx_q)
      3'd0:    digest_word_o = chain[0];
      3'd1:    digest_word_o = chain[1];
      3'd2:    digest_word_o = chain[2];
      3'd3:    digest_word_o = chain[3];
      3'd4:    digest_word_o = chain[4];
      default: digest_word_o = '0;
    endcase
  end

  assign digest_index_o = idx_q;
  assign digest_last_o  = (idx_q == sha1_pkg::LAST_IDX);

  `SHA1_ASSERT_NOW(a_out_core_idle, out_valid_o, !core_busy, "digest offered during compression")
  `SHA1_ASSERT_NOW(a_len_lo_slot, state_q == sha1_pkg::ST_PAD && lenhi_q && !core_busy, pos_q == sha1_pkg::LAST_POS, "length low word misplaced")
  `SHA1_ASSERT_NEXT(a_clear_after_digest, out_xfer && digest_last_o, state_q == sha1_pkg::ST_IDLE && pos_q == '0 && bitlen_q == '0, "engine not cleared after digest")

endmodule
